[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

[rtl/core/rcs_pkg.sv]
// Types and constants for the region RGB565 color statistics core.
`default_nettype none

package rcs_pkg;

  localparam int REG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 16;
  localparam int RB_W      = 5;
  localparam int G_W       = 6;
  localparam int QUO_W     = 6;

  localparam logic [RB_W-1:0] RB_FULL = 5'h1F;
  localparam logic [G_W-1:0]  G_FULL  = 6'h3F;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST = 11'd160;
  localparam logic [REG_W-1:0] WIN_LEFT_RST    = 11'd60;
  localparam logic [REG_W-1:0] WIN_TOP_RST     = 11'd40;
  localparam logic [REG_W-1:0] WIN_RIGHT_RST   = 11'd100;
  localparam logic [REG_W-1:0] WIN_BOTTOM_RST  = 11'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_WIN_LEFT    = 3'd1,
    REG_WIN_TOP     = 3'd2,
    REG_WIN_RIGHT   = 3'd3,
    REG_WIN_BOTTOM  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_W-1:0] frame_width;
    logic [REG_W-1:0] win_left;
    logic [REG_W-1:0] win_top;
    logic [REG_W-1:0] win_right;
    logic [REG_W-1:0] win_bottom;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [RB_W-1:0] avg_red;
    logic [G_W-1:0]  avg_green;
    logic [RB_W-1:0] avg_blue;
    logic [RB_W-1:0] min_red;
    logic [G_W-1:0]  min_green;
    logic [RB_W-1:0] min_blue;
    logic [RB_W-1:0] max_red;
    logic [G_W-1:0]  max_green;
    logic [RB_W-1:0] max_blue;
    logic            empty_window;
  } out_item_t;

  typedef struct packed {
    logic [RB_W-1:0] r_min;
    logic [G_W-1:0]  g_min;
    logic [RB_W-1:0] b_min;
    logic [RB_W-1:0] r_max;
    logic [G_W-1:0]  g_max;
    logic [RB_W-1:0] b_max;
  } minmax_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[rtl/core/region_rgb565_color_stats_core.sv]
// Top level: region color statistics over an RGB565 pixel stream.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in_     | input     | in_valid / in_stall  | rcs_pkg::in_item_t  (pixel, eof)
//   out_    | output    | out_valid / out_stall| rcs_pkg::out_item_t (stats)
//   cfg_    | input     | cfg_valid / cfg_ready| 3-bit register index, 11-bit data
//
// Pixels without end of frame go in at one item per cycle; the accumulator
// registers update on each accepted pixel. An end-of-frame item closes the
// frame: the shared divider then runs three divisions, one 6-bit quotient
// per channel, each launched from ST_LOAD and awaited in ST_DIV, before the
// result register loads from ST_OUT; an empty window skips the divider. The
// load waits while the previous result is still stalled. in_stall stays high for that span.
// Synchronous active-low reset restores the register defaults and clears
// all accumulators. cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"

module region_rgb565_color_stats_core #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // pixel items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire rcs_pkg::in_item_t                 in_data,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output rcs_pkg::out_item_t                     out_data,
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rcs_pkg::REG_W-1:0]         cfg_data
);

  localparam int CAP    = MAX_DIM * MAX_DIM;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int RSUM_W = CNT_W + rcs_pkg::RB_W;
  localparam int GSUM_W = CNT_W + rcs_pkg::G_W;

  typedef enum logic [1:0] {
    ST_IDLE,   // taking pixels
    ST_LOAD,   // launch division for current channel
    ST_DIV,    // wait for quotient
    ST_OUT     // hand result to output register
  } state_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  rcs_pkg::cfg_t cfg_r;
  logic          cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width <= rcs_pkg::FRAME_WIDTH_RST;
      cfg_r.win_left    <= rcs_pkg::WIN_LEFT_RST;
      cfg_r.win_top     <= rcs_pkg::WIN_TOP_RST;
      cfg_r.win_right   <= rcs_pkg::WIN_RIGHT_RST;
      cfg_r.win_bottom  <= rcs_pkg::WIN_BOTTOM_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        rcs_pkg::REG_FRAME_WIDTH: cfg_r.frame_width <= cfg_data;
        rcs_pkg::REG_WIN_LEFT:    cfg_r.win_left    <= cfg_data;
        rcs_pkg::REG_WIN_TOP:     cfg_r.win_top     <= cfg_data;
        rcs_pkg::REG_WIN_RIGHT:   cfg_r.win_right   <= cfg_data;
        rcs_pkg::REG_WIN_BOTTOM:  cfg_r.win_bottom  <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulator and shared divider
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;
  chan_t  ch_r, ch_nxt;

  logic in_acc, acc_clr, div_start, out_load, out_take;

  logic [CNT_W-1:0]  acc_cnt;
  logic [RSUM_W-1:0] acc_rsum, acc_bsum;
  logic [GSUM_W-1:0] acc_gsum;
  rcs_pkg::minmax_t  acc_mm;

  logic [GSUM_W-1:0]              div_dividend;
  rcs_pkg::div_stat_t             div_stat;
  logic [rcs_pkg::QUO_W-1:0]      div_quo;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  rcs_accum #(
    .MAX_DIM (MAX_DIM)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .pix_en_i (in_acc),
    .pixel_i  (in_data.pixel_value),
    .clr_i    (acc_clr),
    .cnt_o    (acc_cnt),
    .rsum_o   (acc_rsum),
    .gsum_o   (acc_gsum),
    .bsum_o   (acc_bsum),
    .mm_o     (acc_mm)
  );

  always_comb begin
    case (ch_r)
      CH_RED:   div_dividend = GSUM_W'(acc_rsum);
      CH_GREEN: div_dividend = acc_gsum;
      CH_BLUE:  div_dividend = GSUM_W'(acc_bsum);
      default:  div_dividend = '0;
    endcase
  end

  rcs_divider #(
    .CNT_W (CNT_W),
    .SUM_W (GSUM_W)
  ) u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (acc_cnt),
    .stat_o     (div_stat),
    .quo_o      (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  logic [rcs_pkg::RB_W-1:0] avg_r_r, avg_r_nxt, avg_b_r, avg_b_nxt;
  logic [rcs_pkg::G_W-1:0]  avg_g_r, avg_g_nxt;
  logic                     out_valid_r, out_valid_nxt;
  rcs_pkg::out_item_t       out_data_r, out_data_nxt, res;
  logic                     empty;

  assign empty    = (acc_cnt == '0);
  assign out_take = out_valid_r && !out_stall;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    res.empty_window = empty;
    res.avg_red      = empty ? '0 : avg_r_r;
    res.avg_green    = empty ? '0 : avg_g_r;
    res.avg_blue     = empty ? '0 : avg_b_r;
    res.min_red      = empty ? '0 : acc_mm.r_min;
    res.min_green    = empty ? '0 : acc_mm.g_min;
    res.min_blue     = empty ? '0 : acc_mm.b_min;
    res.max_red      = empty ? '0 : acc_mm.r_max;
    res.max_green    = empty ? '0 : acc_mm.g_max;
    res.max_blue     = empty ? '0 : acc_mm.b_max;
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    avg_r_nxt     = avg_r_r;
    avg_g_nxt     = avg_g_r;
    avg_b_nxt     = avg_b_r;
    div_start     = 1'b0;
    acc_clr       = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_take) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.end_of_frame) begin
          state_nxt = ST_LOAD;
          ch_nxt    = CH_RED;
        end
      end
      ST_LOAD: begin
        // empty window skips the divider entirely
        if (empty) begin
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          case (ch_r)
            CH_RED:   avg_r_nxt = div_quo[rcs_pkg::RB_W-1:0];
            CH_GREEN: avg_g_nxt = div_quo[rcs_pkg::G_W-1:0];
            CH_BLUE:  avg_b_nxt = div_quo[rcs_pkg::RB_W-1:0];
            default: ;
          endcase
          case (ch_r)
            CH_RED:   begin ch_nxt = CH_GREEN; state_nxt = ST_LOAD; end
            CH_GREEN: begin ch_nxt = CH_BLUE;  state_nxt = ST_LOAD; end
            default:  state_nxt = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_data_nxt  = res;
          out_valid_nxt = 1'b1;
          acc_clr       = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= CH_RED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    avg_r_r    <= avg_r_nxt;
    avg_g_r    <= avg_g_nxt;
    avg_b_r    <= avg_b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_div_only_in_div, clk, rst_n, div_stat.busy || div_stat.done, state_r == ST_DIV)
  `ASSERT_NEXT(a_load_moves_on, clk, rst_n, state_r == ST_LOAD, state_r == ST_DIV || state_r == ST_OUT)
  `ASSERT_NEXT(a_clear_after_out, clk, rst_n, out_load, acc_cnt == '0 && out_valid)

endmodule

`default_nettype wire

[rtl/core/rcs_accum.sv]
// Raster position tracking and per-channel window accumulation.
`default_nettype none

module rcs_accum #(
  parameter int MAX_DIM = 1024,
  localparam int DIM_W  = $clog2(MAX_DIM),
  localparam int CAP    = MAX_DIM * MAX_DIM,
  localparam int CNT_W  = $clog2(CAP + 1),
  localparam int RSUM_W = CNT_W + rcs_pkg::RB_W,
  localparam int GSUM_W = CNT_W + rcs_pkg::G_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rcs_pkg::cfg_t                 cfg_i,
  input  wire logic                          pix_en_i,
  input  wire logic [rcs_pkg::PIX_W-1:0]     pixel_i,
  input  wire logic                          clr_i,
  output logic [CNT_W-1:0]                   cnt_o,
  output logic [RSUM_W-1:0]                  rsum_o,
  output logic [GSUM_W-1:0]                  gsum_o,
  output logic [RSUM_W-1:0]                  bsum_o,
  output rcs_pkg::minmax_t                   mm_o
);

  // compare width: holds any register value, MAX_DIM and position + 1
  localparam int BASE_W = (DIM_W + 1 > rcs_pkg::REG_W) ? DIM_W + 1 : rcs_pkg::REG_W;
  localparam int CW     = BASE_W + 1;

  logic [DIM_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RSUM_W-1:0] rsum_r, rsum_nxt, bsum_r, bsum_nxt;
  logic [GSUM_W-1:0] gsum_r, gsum_nxt;
  rcs_pkg::minmax_t  mm_r, mm_nxt, mm_rst;

  logic [CW-1:0] fw, eff_w, col_inc, row_inc, col_x, row_x;
  logic [rcs_pkg::RB_W-1:0] r_px, b_px;
  logic [rcs_pkg::G_W-1:0]  g_px;
  logic in_win, take;

  always_comb begin
    mm_rst.r_min = rcs_pkg::RB_FULL;
    mm_rst.g_min = rcs_pkg::G_FULL;
    mm_rst.b_min = rcs_pkg::RB_FULL;
    mm_rst.r_max = '0;
    mm_rst.g_max = '0;
    mm_rst.b_max = '0;

    r_px = pixel_i[15:11];
    g_px = pixel_i[10:5];
    b_px = pixel_i[4:0];

    fw = CW'(cfg_i.frame_width);
    if (fw == '0) begin
      eff_w = CW'(1);
    end else if (fw > CW'(MAX_DIM)) begin
      eff_w = CW'(MAX_DIM);
    end else begin
      eff_w = fw;
    end

    col_x   = CW'(col_r);
    row_x   = CW'(row_r);
    col_inc = col_x + CW'(1);
    row_inc = row_x + CW'(1);

    in_win = (col_x >= CW'(cfg_i.win_left)) && (col_x < CW'(cfg_i.win_right)) &&
             (row_x >= CW'(cfg_i.win_top))  && (row_x < CW'(cfg_i.win_bottom));
    take   = in_win && (cnt_r < CNT_W'(CAP));

    col_nxt  = col_r;
    row_nxt  = row_r;
    cnt_nxt  = cnt_r;
    rsum_nxt = rsum_r;
    gsum_nxt = gsum_r;
    bsum_nxt = bsum_r;
    mm_nxt   = mm_r;

    if (clr_i) begin
      col_nxt  = '0;
      row_nxt  = '0;
      cnt_nxt  = '0;
      rsum_nxt = '0;
      gsum_nxt = '0;
      bsum_nxt = '0;
      mm_nxt   = mm_rst;
    end else if (pix_en_i) begin
      if (take) begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        rsum_nxt = rsum_r + RSUM_W'(r_px);
        gsum_nxt = gsum_r + GSUM_W'(g_px);
        bsum_nxt = bsum_r + RSUM_W'(b_px);
        if (r_px < mm_r.r_min) mm_nxt.r_min = r_px;
        if (r_px > mm_r.r_max) mm_nxt.r_max = r_px;
        if (g_px < mm_r.g_min) mm_nxt.g_min = g_px;
        if (g_px > mm_r.g_max) mm_nxt.g_max = g_px;
        if (b_px < mm_r.b_min) mm_nxt.b_min = b_px;
        if (b_px > mm_r.b_max) mm_nxt.b_max = b_px;
      end
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= CW'(MAX_DIM)) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cnt_r  <= '0;
      rsum_r <= '0;
      gsum_r <= '0;
      bsum_r <= '0;
      mm_r   <= mm_rst;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cnt_r  <= cnt_nxt;
      rsum_r <= rsum_nxt;
      gsum_r <= gsum_nxt;
      bsum_r <= bsum_nxt;
      mm_r   <= mm_nxt;
    end
  end

  assign cnt_o  = cnt_r;
  assign rsum_o = rsum_r;
  assign gsum_o = gsum_r;
  assign bsum_o = bsum_r;
  assign mm_o   = mm_r;

endmodule

`default_nettype wire

[rtl/core/rcs_divider.sv]
// Shared restoring divider: one quotient bit per cycle, short quotient.
`default_nettype none

module rcs_divider #(
  parameter int CNT_W = 21,
  parameter int SUM_W = 27
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start_i,
  input  wire logic [SUM_W-1:0]              dividend_i,
  input  wire logic [CNT_W-1:0]              divisor_i,
  output rcs_pkg::div_stat_t                 stat_o,
  output logic [rcs_pkg::QUO_W-1:0]          quo_o
);

  localparam int QW    = rcs_pkg::QUO_W;
  localparam int DEN_W = CNT_W + QW - 1;
  localparam int STP_W = $clog2(QW + 1);

  logic [SUM_W-1:0] rem_r, rem_nxt, den_x;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [STP_W-1:0] step_r, step_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt, ge;

  always_comb begin
    den_x    = SUM_W'(den_r);
    ge       = rem_r >= den_x;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      rem_nxt  = dividend_i;
      den_nxt  = {divisor_i, {(QW-1){1'b0}}};
      quo_nxt  = '0;
      step_nxt = STP_W'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // divisor is pre-shifted by one less than the quotient width and walks down a bit per step
      rem_nxt  = ge ? rem_r - den_x : rem_r;
      den_nxt  = den_r >> 1;
      quo_nxt  = {quo_r[QW-2:0], ge};
      step_nxt = step_r - STP_W'(1);
      if (step_r == STP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;
  assign quo_o       = quo_r;

endmodule

`default_nettype wire

[sim/rgb_stats_checker.sv]
`timescale 1ns / 100ps
// Checker for the region color statistics core: watches the channels, predicts and compares.
module rgb_stats_checker
  import rcs_pkg::*;
#(
  parameter int MAX_DIM = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int         mismatches,
  output int         pending,
  output int         checked,
  output int         empties
);

  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = 2 * POS_W + 1;
  localparam int COUNT_CAP = MAX_DIM * MAX_DIM;

  cfg_t              regs;
  logic [POS_W-1:0]  col_pos;
  logic [POS_W-1:0]  row_pos;
  logic [CNT_W-1:0]  win_count;
  logic [CNT_W+3:0]  red_acc;
  logic [CNT_W+4:0]  green_acc;
  logic [CNT_W+3:0]  blue_acc;
  logic [RB_W-1:0]   red_lo, red_hi, blue_lo, blue_hi;
  logic [G_W-1:0]    green_lo, green_hi;
  out_item_t         stats_due_q[$];

  task automatic log_mismatch(input string what, input int got, input int want);
    $display("[%0t] result %0d %s: got %0d, expected %0d", $realtime, checked, what, got, want);
    mismatches++;
  endtask

  task automatic cmp_field(input string what, input int got, input int want);
    if (got != want)
      log_mismatch(what, got, want);
  endtask

  task automatic clear_frame_state();
    col_pos   = '0;
    row_pos   = '0;
    win_count = '0;
    red_acc   = '0;
    green_acc = '0;
    blue_acc  = '0;
    red_lo    = RB_FULL;
    green_lo  = G_FULL;
    blue_lo   = RB_FULL;
    red_hi    = '0;
    green_hi  = '0;
    blue_hi   = '0;
  endtask

  // zero width counts as one column, oversize clamps to the max dimension
  function automatic int unsigned line_width();
    if (regs.frame_width == '0)
      return 1;
    if (int'(regs.frame_width) > MAX_DIM)
      return MAX_DIM;
    return regs.frame_width;
  endfunction

  task automatic fold_pixel(input in_item_t px);
    logic [RB_W-1:0] r, b;
    logic [G_W-1:0]  g;
    logic            hit;
    out_item_t       res;
    r = px.pixel_value[15:11];
    g = px.pixel_value[10:5];
    b = px.pixel_value[4:0];
    hit = (col_pos >= regs.win_left) && (col_pos < regs.win_right) &&
          (row_pos >= regs.win_top) && (row_pos < regs.win_bottom);
    if (hit && int'(win_count) < COUNT_CAP) begin
      red_acc   += r;
      green_acc += g;
      blue_acc  += b;
      if (r < red_lo)   red_lo   = r;
      if (r > red_hi)   red_hi   = r;
      if (g < green_lo) green_lo = g;
      if (g > green_hi) green_hi = g;
      if (b < blue_lo)  blue_lo  = b;
      if (b > blue_hi)  blue_hi  = b;
      win_count++;
    end
    if (int'(col_pos) + 1 >= line_width()) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= MAX_DIM)
        row_pos = '0;
      else
        row_pos++;
    end else begin
      col_pos++;
    end
    if (px.end_of_frame) begin
      res = '0;
      if (win_count == '0) begin
        res.empty_window = 1'b1;
        empties++;
      end else begin
        res.avg_red   = RB_W'(32'(red_acc) / 32'(win_count));
        res.avg_green = G_W'(32'(green_acc) / 32'(win_count));
        res.avg_blue  = RB_W'(32'(blue_acc) / 32'(win_count));
        res.min_red   = red_lo;
        res.min_green = green_lo;
        res.min_blue  = blue_lo;
        res.max_red   = red_hi;
        res.max_green = green_hi;
        res.max_blue  = blue_hi;
      end
      stats_due_q.push_back(res);
      clear_frame_state();
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (stats_due_q.size() == 0) begin
      log_mismatch("arrived with none outstanding", int'(got), 0);
    end else begin
      want = stats_due_q.pop_front();
      cmp_field("avg_red",      got.avg_red,      want.avg_red);
      cmp_field("avg_green",    got.avg_green,    want.avg_green);
      cmp_field("avg_blue",     got.avg_blue,     want.avg_blue);
      cmp_field("min_red",      got.min_red,      want.min_red);
      cmp_field("min_green",    got.min_green,    want.min_green);
      cmp_field("min_blue",     got.min_blue,     want.min_blue);
      cmp_field("max_red",      got.max_red,      want.max_red);
      cmp_field("max_green",    got.max_green,    want.max_green);
      cmp_field("max_blue",     got.max_blue,     want.max_blue);
      cmp_field("empty_window", got.empty_window, want.empty_window);
    end
    checked++;
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    empties    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.frame_width = FRAME_WIDTH_RST;
      regs.win_left    = WIN_LEFT_RST;
      regs.win_top     = WIN_TOP_RST;
      regs.win_right   = WIN_RIGHT_RST;
      regs.win_bottom  = WIN_BOTTOM_RST;
      clear_frame_state();
      stats_due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: regs.frame_width = cfg_data;
          REG_WIN_LEFT:    regs.win_left    = cfg_data;
          REG_WIN_TOP:     regs.win_top     = cfg_data;
          REG_WIN_RIGHT:   regs.win_right   = cfg_data;
          REG_WIN_BOTTOM:  regs.win_bottom  = cfg_data;
          default: ;
        endcase
      end
      // a result never stems from the item accepted at the same edge
      if (out_valid && !out_stall)
        check_result(out_data);
      if (in_valid && !in_stall)
        fold_pixel(in_data);
    end
    pending = stats_due_q.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the region color statistics core: stimulus, reset and verdict.
module tb;
  import rcs_pkg::*;

  localparam int MAX_DIM = 1024;
  // margin for an in-flight eof divide to finish before touching registers
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 70;
  localparam logic [REG_W-1:0]     REG_MAX       = '1;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = '1;  // decodes to no register

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [REG_W-1:0]     cfg_data = '0;

  int mismatches, pending, checked, empties;
  int n_pixels = 0;
  int n_settings = 0;
  bit calm = 1'b0;  // set during the no-idle stretch
  bit drained;

  always #4 clk = ~clk;

  region_rgb565_color_stats_core #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgb_stats_checker #(.MAX_DIM(MAX_DIM)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .empties    (empties)
  );

  // Result-side backpressure: ~35% stall, none in the calm stretch.
  always @(negedge clk)
    out_stall = !calm && ($urandom_range(99) < 35);

  // All tasks below start and end at a falling edge.

  // One pixel item; random gap cycles ahead of it, then hold until taken.
  task automatic push_pixel(input logic [PIX_W-1:0] pv, input logic eof);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{pixel_value: pv, end_of_frame: eof};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_pixels++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    in_valid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [REG_W-1:0] fw, wl, wt, wr, wb);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_WIN_LEFT,    wl);
    write_reg(REG_WIN_TOP,     wt);
    write_reg(REG_WIN_RIGHT,   wr);
    write_reg(REG_WIN_BOTTOM,  wb);
    n_settings++;
  endtask

  // Block idle: every result back, then let any in-flight divide finish.
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly random words, with a fair share of per-channel extremes.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hF800;   // red only
      3: return 16'h07E0;   // green only
      4: return 16'h001F;   // blue only
      default: return PIX_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++)
      push_pixel(pick_pixel(), i == len - 1);
  endtask

  // One window span: mostly small and inside a short frame, sometimes
  // wide open, inverted/empty, out of range, or fully random.
  task automatic pick_span(output logic [REG_W-1:0] lo, output logic [REG_W-1:0] hi);
    case ($urandom_range(11))
      0: begin
        lo = REG_W'($urandom_range(REG_MAX));
        hi = REG_W'($urandom_range(REG_MAX));
      end
      1: begin
        lo = '0;
        hi = REG_MAX;
      end
      2: begin
        lo = REG_W'($urandom_range(3, 8));
        hi = lo - REG_W'($urandom_range(0, 3));
      end
      3: begin
        lo = REG_W'(MAX_DIM);
        hi = REG_MAX;
      end
      default: begin
        lo = REG_W'($urandom_range(0, 6));
        hi = lo + REG_W'($urandom_range(1, 8));
      end
    endcase
  endtask

  task automatic random_settings();
    logic [REG_W-1:0] fw, wl, wt, wr, wb;
    case ($urandom_range(9))
      0: fw = '0;
      1: fw = REG_W'(1);
      2: fw = REG_W'(MAX_DIM);
      3: fw = REG_MAX;
      default: fw = REG_W'($urandom_range(2, 12));
    endcase
    pick_span(wl, wr);
    pick_span(wt, wb);
    apply_settings(fw, wl, wt, wr, wb);
  endtask

  initial begin
    int sent, len;

    // reset held low from the start, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // reset window sits far from the first pixels: empty window
    push_pixel(16'h1234, 1'b0);
    push_pixel(16'hABCD, 1'b0);
    push_pixel(16'h5555, 1'b1);

    // 4x2 window covering the whole short frame, channel extremes
    settle();
    apply_settings(REG_W'(4), '0, '0, REG_W'(4), REG_W'(2));
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'hF800, 1'b0);
    push_pixel(16'h07E0, 1'b0);
    push_pixel(16'h001F, 1'b0);
    push_pixel(16'h8410, 1'b0);
    push_pixel(16'h7BEF, 1'b0);
    push_pixel(16'hAAAA, 1'b1);

    // inverted columns and zero-height rows: empty window
    settle();
    apply_settings(REG_W'(4), REG_W'(3), REG_W'(2), REG_W'(1), REG_W'(2));
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'hFFFF, 1'b1);

    // zero frame width acts as one column; rows 1..2 in window
    settle();
    apply_settings('0, '0, REG_W'(1), REG_W'(1), REG_W'(3));
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h39E7, 1'b0);
    push_pixel(16'hC618, 1'b0);
    push_pixel(16'h0000, 1'b1);

    // write to an unmapped index must change nothing; all-ones registers
    settle();
    write_reg(SPARE_REG_IDX, '0);
    apply_settings(REG_MAX, '0, '0, REG_MAX, REG_MAX);
    push_pixel(16'h0841, 1'b0);
    push_pixel(16'hF7DE, 1'b0);
    push_pixel(16'h4208, 1'b1);

    // --- random phases of short frames; one phase runs with no idling ---
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      random_settings();
      calm = (ph == 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 30);
        if (sent + len > PHASE_ITEMS)
          len = PHASE_ITEMS - sent;
        send_frame(len);
        sent += len;
      end
    end
    calm = 1'b0;

    // --- drain ---
    in_valid = 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pending != 0; k++)
      @(negedge clk);
    drained = (pending == 0);
    if (!drained) begin
      $display("%0d statistics results still outstanding", pending);
      $display("end of test: mismatches");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(negedge clk);
      $display("%0d pixels streamed, %0d statistics results checked (%0d empty windows)",
               n_pixels, checked, empties);
      $display("%0d register settings incl. zero/oversize width and inverted bounds",
               n_settings);
      if (mismatches == 0 && pending == 0)
        $display("end of test: clean");
      else
        $display("end of test: mismatches");
      $finish;
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("timeout waiting on the core");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
